// ===== rtl/npc_pkg.sv =====
package npc_pkg;

  localparam int RomSize = 256;

  typedef logic [7:0]  comp_t;
  typedef logic [17:0] dist_t;
  typedef logic [23:0] rgb_t;

  // standard vga default palette, packed {red, green, blue}
  localparam rgb_t VGA_ROM [RomSize] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA, 24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
    24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF, 24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF,
    24'h000000, 24'h141414, 24'h202020, 24'h2C2C2C, 24'h383838, 24'h454545, 24'h515151, 24'h616161,
    24'h717171, 24'h828282, 24'h929292, 24'hA2A2A2, 24'hB6B6B6, 24'hCBCBCB, 24'hE3E3E3, 24'hFFFFFF,
    24'h0000FF, 24'h4100FF, 24'h7D00FF, 24'hBE00FF, 24'hFF00FF, 24'hFF00BE, 24'hFF007D, 24'hFF0041,
    24'hFF0000, 24'hFF4100, 24'hFF7D00, 24'hFFBE00, 24'hFFFF00, 24'hBEFF00, 24'h7DFF00, 24'h41FF00,
    24'h00FF00, 24'h00FF41, 24'h00FF7D, 24'h00FFBE, 24'h00FFFF, 24'h00BEFF, 24'h007DFF, 24'h0041FF,
    24'h7D7DFF, 24'h9E7DFF, 24'hBE7DFF, 24'hDF7DFF, 24'hFF7DFF, 24'hFF7DDF, 24'hFF7DBE, 24'hFF7D9E,
    24'hFF7D7D, 24'hFF9E7D, 24'hFFBE7D, 24'hFFDF7D, 24'hFFFF7D, 24'hDFFF7D, 24'hBEFF7D, 24'h9EFF7D,
    24'h7DFF7D, 24'h7DFF9E, 24'h7DFFBE, 24'h7DFFDF, 24'h7DFFFF, 24'h7DDFFF, 24'h7DBEFF, 24'h7D9EFF,
    24'hB6B6FF, 24'hC7B6FF, 24'hDBB6FF, 24'hEBB6FF, 24'hFFB6FF, 24'hFFB6EB, 24'hFFB6DB, 24'hFFB6C7,
    24'hFFB6B6, 24'hFFC7B6, 24'hFFDBB6, 24'hFFEBB6, 24'hFFFFB6, 24'hEBFFB6, 24'hDBFFB6, 24'hC7FFB6,
    24'hB6FFB6, 24'hB6FFC7, 24'hB6FFDB, 24'hB6FFEB, 24'hB6FFFF, 24'hB6EBFF, 24'hB6DBFF, 24'hB6C7FF,
    24'h000071, 24'h1C0071, 24'h380071, 24'h550071, 24'h710071, 24'h710055, 24'h710038, 24'h71001C,
    24'h710000, 24'h711C00, 24'h713800, 24'h715500, 24'h717100, 24'h557100, 24'h387100, 24'h1C7100,
    24'h007100, 24'h00711C, 24'h007138, 24'h007155, 24'h007171, 24'h005571, 24'h003871, 24'h001C71,
    24'h383871, 24'h453871, 24'h553871, 24'h613871, 24'h713871, 24'h713861, 24'h713855, 24'h713845,
    24'h713838, 24'h714538, 24'h715538, 24'h716138, 24'h717138, 24'h617138, 24'h557138, 24'h457138,
    24'h387138, 24'h387145, 24'h387155, 24'h387161, 24'h387171, 24'h386171, 24'h385571, 24'h384571,
    24'h515171, 24'h595171, 24'h615171, 24'h695171, 24'h715171, 24'h715169, 24'h715161, 24'h715159,
    24'h715151, 24'h715951, 24'h716151, 24'h716951, 24'h717151, 24'h697151, 24'h617151, 24'h597151,
    24'h517151, 24'h517159, 24'h517161, 24'h517169, 24'h517171, 24'h516971, 24'h516171, 24'h515971,
    24'h000041, 24'h100041, 24'h200041, 24'h300041, 24'h410041, 24'h410030, 24'h410020, 24'h410010,
    24'h410000, 24'h411000, 24'h412000, 24'h413000, 24'h414100, 24'h304100, 24'h204100, 24'h104100,
    24'h004100, 24'h004110, 24'h004120, 24'h004130, 24'h004141, 24'h003041, 24'h002041, 24'h001041,
    24'h202041, 24'h282041, 24'h302041, 24'h382041, 24'h412041, 24'h412038, 24'h412030, 24'h412028,
    24'h412020, 24'h412820, 24'h413020, 24'h413820, 24'h414120, 24'h384120, 24'h304120, 24'h284120,
    24'h204120, 24'h204128, 24'h204130, 24'h204138, 24'h204141, 24'h203841, 24'h203041, 24'h202841,
    24'h2C2C41, 24'h302C41, 24'h342C41, 24'h3C2C41, 24'h412C41, 24'h412C3C, 24'h412C34, 24'h412C30,
    24'h412C2C, 24'h41302C, 24'h41342C, 24'h413C2C, 24'h41412C, 24'h3C412C, 24'h34412C, 24'h30412C,
    24'h2C412C, 24'h2C4130, 24'h2C4134, 24'h2C413C, 24'h2C4141, 24'h2C3C41, 24'h2C3441, 24'h2C3041,
    24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000
  };

  // data handed from one cell to the next
  typedef struct packed {
    logic  valid;
    rgb_t  pixel;
    dist_t best_dist;
    comp_t best_idx;
  } link_t;

  function automatic logic [15:0] sq_diff(input comp_t a, input comp_t b);
    logic [7:0] d;
    begin
      d = (a >= b) ? a - b : b - a;
      return 16'(d) * 16'(d);
    end
  endfunction

  function automatic dist_t dist_of(input rgb_t p, input rgb_t c);
    begin
      return dist_t'(sq_diff(p[23:16], c[23:16])) + dist_t'(sq_diff(p[15:8], c[15:8]))
           + dist_t'(sq_diff(p[7:0], c[7:0]));
    end
  endfunction

endpackage

// ===== rtl/npc_cell.sv =====
module npc_cell #(
  parameter int ENTRY = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  npc_pkg::link_t link_in,
  output npc_pkg::link_t link_out
);

  npc_pkg::link_t link_r, link_nxt;
  npc_pkg::dist_t cell_dist;

  // compare this cell's palette entry, strictly smaller wins
  always_comb begin
    cell_dist = npc_pkg::dist_of(link_in.pixel, npc_pkg::VGA_ROM[ENTRY]);
    link_nxt = link_in;
    if (cell_dist < link_in.best_dist) begin
      link_nxt.best_dist = cell_dist;
      link_nxt.best_idx  = npc_pkg::comp_t'(ENTRY);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r.valid <= 1'b0;
    end else if (adv) begin
      link_r <= link_nxt;
    end
  end

  assign link_out = link_r;

endmodule

// ===== rtl/nearest_palette_color_unit.sv =====
// nearest palette colour unit
// in_red/in_green/in_blue enter on in_valid & in_ready; out_palette_index
// leaves on out_valid & out_ready. the result is the index of the closest
// entry of the vga default palette by squared rgb distance, lowest index
// on ties.
// a chain of Used-1 cells (Used is PALETTE_ENTRIES clamped to 1..256),
// one palette entry each, follows an entry register; every cell compares
// one entry and passes the best so far. a pixel passes the entry register
// and then each cell's register in turn.
// throughput: one pixel per cycle while not stalled; the whole chain advances together.
// when the receiver stalls with a result waiting, the whole chain holds,
// bubbles included, and in_ready drops in that same cycle.
// reset clears all valid flags; no result is pending after reset.
module nearest_palette_color_unit #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_palette_index
);

  // search never runs past the rom and always covers entry 0
  localparam int Used = (PALETTE_ENTRIES > npc_pkg::RomSize) ? npc_pkg::RomSize :
                        ((PALETTE_ENTRIES < 1) ? 1 : PALETTE_ENTRIES);
  localparam int Cells = Used - 1;

  npc_pkg::link_t links [Cells+1];
  npc_pkg::link_t head_r, head_nxt;
  logic adv;

  // whole chain moves when the last slot is free or being taken
  assign adv      = !links[Cells].valid || out_ready;
  assign in_ready = adv;

  // entry register: distance to palette entry 0
  always_comb begin
    head_nxt.valid     = in_valid;
    head_nxt.pixel     = {in_red, in_green, in_blue};
    head_nxt.best_dist = npc_pkg::dist_of(head_nxt.pixel, npc_pkg::VGA_ROM[0]);
    head_nxt.best_idx  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.valid <= 1'b0;
    end else if (adv) begin
      head_r <= head_nxt;
    end
  end

  assign links[0] = head_r;

  // one cell per remaining palette entry
  for (genvar i = 1; i <= Cells; i++) begin : g_cell
    npc_cell #(.ENTRY(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .link_in (links[i-1]),
      .link_out(links[i])
    );
  end

  assign out_valid         = links[Cells].valid;
  assign out_palette_index = links[Cells].best_idx;

endmodule
